// ----- rtl/core/blpg_pkg.sv -----
`timescale 1ns / 1ps

package blpg_pkg;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [31:0] BASE_RESET = 32'hC800_0000;
  localparam int ROW_SHIFT = 10;
  localparam int COL_SHIFT = 1;

  localparam int CMD_DEPTH_DEFAULT = 2;
  localparam int PIX_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic        is_load;
    logic        steep;
    logic [8:0]  major_pos;
    logic [8:0]  major_end;
    logic [8:0]  minor_pos;
    logic [8:0]  delta_major;
    logic [8:0]  delta_minor;
    logic        minor_down;
    logic [10:0] err_init;
    logic [15:0] color;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [31:0] addr;
    logic [15:0] color;
    logic        last;
  } pix_t;

  typedef struct packed {
    logic cmd_pop;
    logic pix_push;
    logic active;
  } back_status_t;

endpackage

// ----- rtl/core/blpg_queue.sv -----
`timescale 1ns / 1ps

module blpg_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/blpg_front.sv -----
`timescale 1ns / 1ps

module blpg_front (
  input  logic            mode,
  input  logic [8:0]      x_start,
  input  logic [7:0]      y_start,
  input  logic [8:0]      x_end,
  input  logic [7:0]      y_end,
  input  logic [15:0]     pen_color,
  output blpg_pkg::cmd_t  cmd
);

  import blpg_pkg::*;

  logic [8:0] dx;
  logic [7:0] dy;
  logic       steep;
  logic [8:0] ma, na, mb, nb;
  logic [8:0] lo_major, hi_major, lo_minor, hi_minor;
  logic [8:0] dmaj;

  always_comb begin
    dx = (x_start > x_end) ? x_start - x_end : x_end - x_start;
    dy = (y_start > y_end) ? y_start - y_end : y_end - y_start;
    steep = {1'b0, dy} > dx;

    if (steep) begin
      ma = {1'b0, y_start};
      na = x_start;
      mb = {1'b0, y_end};
      nb = x_end;
    end else begin
      ma = x_start;
      na = {1'b0, y_start};
      mb = x_end;
      nb = {1'b0, y_end};
    end

    // walk the major axis upward
    if (ma > mb) begin
      lo_major = mb;
      hi_major = ma;
      lo_minor = nb;
      hi_minor = na;
    end else begin
      lo_major = ma;
      hi_major = mb;
      lo_minor = na;
      hi_minor = nb;
    end

    dmaj = hi_major - lo_major;

    cmd.is_load     = (mode == MODE_LOAD);
    cmd.steep       = steep;
    cmd.major_pos   = lo_major;
    cmd.major_end   = hi_major;
    cmd.minor_pos   = lo_minor;
    cmd.delta_major = dmaj;
    cmd.delta_minor = (lo_minor > hi_minor) ? lo_minor - hi_minor : hi_minor - lo_minor;
    cmd.minor_down  = !(lo_minor < hi_minor);
    cmd.err_init    = -{3'b000, dmaj[8:1]};
    cmd.color       = pen_color;
  end

endmodule

// ----- rtl/core/blpg_back.sv -----
`timescale 1ns / 1ps

module blpg_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            buffer_base,
  input  logic                   cmd_valid,
  input  blpg_pkg::cmd_t         cmd,
  input  logic                   pix_full,
  output blpg_pkg::pix_t         pix,
  output blpg_pkg::back_status_t status
);

  import blpg_pkg::*;

  logic        active;
  logic        steep;
  logic [8:0]  major_pos;
  logic [8:0]  major_end;
  logic [8:0]  minor_pos;
  logic [10:0] err_acc;
  logic [8:0]  delta_major;
  logic [8:0]  delta_minor;
  logic        minor_down;
  logic [15:0] draw_color;

  logic        cmd_pop;
  logic        emit;
  logic        last;
  logic [8:0]  px;
  logic [7:0]  py;
  logic [10:0] err_sum;
  logic        minor_move;
  logic [10:0] err_next;
  logic [31:0] offset;

  always_comb begin
    cmd_pop = cmd_valid && (cmd.is_load || !active || !pix_full);
    emit    = cmd_pop && !cmd.is_load && active;
    last    = (major_pos >= major_end);

    if (steep) begin
      px = minor_pos;
      py = major_pos[7:0];
    end else begin
      px = major_pos;
      py = minor_pos[7:0];
    end

    offset = (32'(py) << ROW_SHIFT) | (32'(px) << COL_SHIFT);

    err_sum    = err_acc + {2'b00, delta_minor};
    minor_move = !err_sum[10] && (delta_minor != '0);
    err_next   = minor_move ? err_sum - {2'b00, delta_major} : err_sum;

    pix.x     = px;
    pix.y     = py;
    pix.addr  = buffer_base + offset;
    pix.color = draw_color;
    pix.last  = last;

    status.cmd_pop  = cmd_pop;
    status.pix_push = emit;
    status.active   = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      steep       <= 1'b0;
      major_pos   <= '0;
      major_end   <= '0;
      minor_pos   <= '0;
      err_acc     <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      minor_down  <= 1'b0;
      draw_color  <= '0;
    end else if (cmd_pop && cmd.is_load) begin
      active      <= 1'b1;
      steep       <= cmd.steep;
      major_pos   <= cmd.major_pos;
      major_end   <= cmd.major_end;
      minor_pos   <= cmd.minor_pos;
      err_acc     <= cmd.err_init;
      delta_major <= cmd.delta_major;
      delta_minor <= cmd.delta_minor;
      minor_down  <= cmd.minor_down;
      draw_color  <= cmd.color;
    end else if (emit) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        err_acc   <= err_next;
        major_pos <= major_pos + 1'b1;
        if (minor_move) begin
          minor_pos <= minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bresenham_line_pixel_generator.sv -----
`timescale 1ns / 1ps

// line rasterizer with queue-style channels on both sides
// input: drive mode and the endpoint/color fields with push; a beat is taken
//   when push is high and full is low. mode 0 loads a line (no pixel out,
//   any line in progress is dropped), mode 1 asks for the next pixel.
// output: while empty is low the oldest pixel sits on pixel_x, pixel_y,
//   pixel_address, pixel_color and last_pixel; pop with empty low takes it.
//   a step while no line is active yields nothing.
// cfg: buffer_base is written on any edge with cfg_write_en high; write it
//   only while no beats are in flight.
// a step beat is held in the command queue and its pixel in the pixel queue.
// throughput: one beat per cycle while full is low; the command queue and the
//   pixel queue (CMD_DEPTH, PIX_DEPTH) hold the work while either side stalls,
//   and the walker retires one command per cycle unless a step meets pix_full.
// a stalled receiver fills the pixel queue, then the command queue, then
//   full rises. reset empties both queues, leaves the walker idle and sets
//   buffer_base to 0xC8000000; there is no clearing pass.
module bresenham_line_pixel_generator #(
  parameter int CMD_DEPTH = blpg_pkg::CMD_DEPTH_DEFAULT,
  parameter int PIX_DEPTH = blpg_pkg::PIX_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [8:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [8:0]  x_end,
  input  logic [7:0]  y_end,
  input  logic [15:0] pen_color,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  pixel_x,
  output logic [7:0]  pixel_y,
  output logic [31:0] pixel_address,
  output logic [15:0] pixel_color,
  output logic        last_pixel,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data
);

  import blpg_pkg::*;

  logic         [31:0] buffer_base;
  cmd_t                front_cmd;
  cmd_t                cmd_head;
  logic                cmd_empty;
  logic                pix_full;
  pix_t                back_pix;
  pix_t                pix_head;
  back_status_t        back_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= BASE_RESET;
    end else if (cfg_write_en) begin
      buffer_base <= cfg_write_data;
    end
  end

  blpg_front u_front (
    .mode      (mode),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .pen_color (pen_color),
    .cmd       (front_cmd)
  );

  blpg_queue #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (back_stat.cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  blpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .buffer_base (buffer_base),
    .cmd_valid   (!cmd_empty),
    .cmd         (cmd_head),
    .pix_full    (pix_full),
    .pix         (back_pix),
    .status      (back_stat)
  );

  blpg_queue #(
    .T     (pix_t),
    .DEPTH (PIX_DEPTH)
  ) u_pix_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (back_stat.pix_push),
    .push_data (back_pix),
    .full      (pix_full),
    .pop       (pop),
    .pop_data  (pix_head),
    .empty     (empty)
  );

  assign pixel_x       = pix_head.x;
  assign pixel_y       = pix_head.y;
  assign pixel_address = pix_head.addr;
  assign pixel_color   = pix_head.color;
  assign last_pixel    = pix_head.last;

`ifndef SYNTHESIS
  a_no_pix_overflow: assert property (@(posedge clk) disable iff (rst)
    back_stat.pix_push |-> !pix_full)
    else $error("pixel pushed into a full queue");

  a_push_needs_line: assert property (@(posedge clk) disable iff (rst)
    back_stat.pix_push |-> back_stat.active)
    else $error("pixel emitted with no active line");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(back_stat.active) |-> $past(back_stat.pix_push && back_pix.last))
    else $error("walker went idle without a last pixel");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import blpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic        mode;
  logic [8:0]  x_start;
  logic [7:0]  y_start;
  logic [8:0]  x_end;
  logic [7:0]  y_end;
  logic [15:0] pen_color;
  logic        empty;
  logic        pop;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [31:0] pixel_address;
  logic [15:0] pixel_color;
  logic        last_pixel;
  logic        cfg_write_en;
  logic [31:0] cfg_write_data;

  // line walker mirror
  logic [31:0]        model_base = BASE_RESET;
  logic               line_active = 1'b0;
  logic               line_steep = 1'b0;
  logic               walk_down = 1'b0;
  logic [8:0]         major_at = '0;
  logic [8:0]         major_stop = '0;
  logic [8:0]         minor_at = '0;
  logic [8:0]         span_major = '0;
  logic [8:0]         span_minor = '0;
  logic signed [10:0] err_term = '0;
  logic [15:0]        line_rgb = '0;

  pix_t pending_pixels[$];

  int send_gap_max = 0;
  int pop_gap_max = 0;
  int pop_hold_req = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int useful_beats = 0;
  int lines_loaded = 0;
  int pixels_checked = 0;
  int base_settings = 0;

  bresenham_line_pixel_generator dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .pen_color(pen_color),
    .empty(empty),
    .pop(pop),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_address(pixel_address),
    .pixel_color(pixel_color),
    .last_pixel(last_pixel),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always #5 clk = ~clk;

  function automatic logic [8:0] dist9(input logic [8:0] a, input logic [8:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic trace_beat(input logic m, input logic [8:0] xs, input logic [7:0] ys,
                            input logic [8:0] xe, input logic [7:0] ye,
                            input logic [15:0] rgb);
    logic [8:0] ma, na, mb, nb;
    pix_t px;
    if (m == MODE_LOAD) begin
      line_steep = dist9({1'b0, ys}, {1'b0, ye}) > dist9(xs, xe);
      if (line_steep) begin
        ma = {1'b0, ys}; na = xs; mb = {1'b0, ye}; nb = xe;
      end else begin
        ma = xs; na = {1'b0, ys}; mb = xe; nb = {1'b0, ye};
      end
      if (ma > mb) begin
        {ma, mb} = {mb, ma};
        {na, nb} = {nb, na};
      end
      major_at = ma;
      major_stop = mb;
      minor_at = na;
      span_major = mb - ma;
      span_minor = dist9(na, nb);
      walk_down = !(na < nb);
      err_term = -$signed({2'b00, span_major >> 1});
      line_rgb = rgb;
      line_active = 1'b1;
      useful_beats++;
      lines_loaded++;
    end else if (line_active) begin
      px.x = line_steep ? minor_at : major_at;
      px.y = line_steep ? major_at[7:0] : minor_at[7:0];
      px.addr = model_base + ({24'd0, px.y} << ROW_SHIFT) + ({23'd0, px.x} << COL_SHIFT);
      px.color = line_rgb;
      px.last = major_at >= major_stop;
      pending_pixels.push_back(px);
      useful_beats++;
      if (px.last) begin
        line_active = 1'b0;
      end else begin
        err_term = err_term + $signed({2'b00, span_minor});
        if (err_term >= 0 && span_minor != 0) begin
          minor_at = walk_down ? minor_at - 9'd1 : minor_at + 9'd1;
          err_term = err_term - $signed({2'b00, span_major});
        end
        major_at = major_at + 9'd1;
      end
    end
  endtask

  task automatic send_beat(input logic m, input logic [8:0] xs, input logic [7:0] ys,
                           input logic [8:0] xe, input logic [7:0] ye,
                           input logic [15:0] rgb);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    pen_color <= rgb;
    do @(posedge clk); while (full);
    trace_beat(m, xs, ys, xe, ye, rgb);
  endtask

  // endpoint fields are ignored on a step, so they carry noise
  task automatic send_step();
    send_beat(MODE_STEP, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
              9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic settle_queue();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    settle_queue();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    model_base = value;
    base_settings++;
  endtask

  task automatic random_line();
    logic [8:0]  xs, xe;
    logic [7:0]  ys, ye;
    logic [15:0] rgb;
    int pick, dx, dy, span, steps, k;
    pick = $urandom_range(0, 99);
    rgb = 16'($urandom_range(0, 65535));
    if (pick < 3) begin
      xs = 9'($urandom_range(0, 511)); ys = 8'($urandom_range(0, 255));
      xe = 9'($urandom_range(0, 511)); ye = 8'($urandom_range(0, 255));
    end else if (pick < 8) begin
      xs = 9'($urandom_range(0, 319)); ys = 8'($urandom_range(0, 239));
      xe = 9'($urandom_range(0, 319)); ye = 8'($urandom_range(0, 239));
    end else begin
      xs = 9'($urandom_range(12, 307)); ys = 8'($urandom_range(12, 227));
      xe = 9'(int'(xs) + int'($urandom_range(0, 24)) - 12);
      ye = 8'(int'(ys) + int'($urandom_range(0, 24)) - 12);
    end
    dx = int'(dist9(xs, xe));
    dy = int'(dist9({1'b0, ys}, {1'b0, ye}));
    span = ((dx > dy) ? dx : dy) + 1;
    pick = $urandom_range(0, 99);
    if (pick < 5) steps = 0;
    else if (pick < 15) steps = $urandom_range(1, span);
    else if (pick < 25) steps = span + $urandom_range(1, 3);
    else steps = span;
    send_beat(MODE_LOAD, xs, ys, xe, ye, rgb);
    for (k = 0; k < steps; k++) send_step();
  endtask

  task automatic test_idle_and_points();
    send_gap_max = 3;
    pop_gap_max = 3;
    send_step();
    send_beat(MODE_LOAD, 9'd0, 8'd0, 9'd0, 8'd0, 16'h0000);
    send_step();
    send_step();
    send_beat(MODE_LOAD, 9'd511, 8'd255, 9'd511, 8'd255, 16'hFFFF);
    send_step();
  endtask

  task automatic test_flat_lines();
    send_beat(MODE_LOAD, 9'd10, 8'd20, 9'd11, 8'd20, 16'hA5A5);
    send_step();
    send_step();
    send_beat(MODE_LOAD, 9'd30, 8'd41, 9'd30, 8'd40, 16'h5A5A);
    send_step();
    send_step();
  endtask

  // steep line whose minor axis walks downward
  task automatic test_steep_reversed();
    int k;
    send_beat(MODE_LOAD, 9'd40, 8'd20, 9'd38, 8'd25, 16'hF800);
    for (k = 0; k < 6; k++) send_step();
  endtask

  task automatic test_load_drops_line();
    send_beat(MODE_LOAD, 9'd0, 8'd0, 9'd20, 8'd5, 16'h001F);
    send_step();
    send_step();
    send_beat(MODE_LOAD, 9'd5, 8'd5, 9'd6, 8'd6, 16'h07E0);
    send_step();
    send_step();
  endtask

  task automatic test_buffer_base();
    logic [31:0] bases [5];
    int i;
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, BASE_RESET};
    bases[3] = $urandom;
    for (i = 0; i < 5; i++) begin
      write_base(bases[i]);
      repeat (3) random_line();
    end
  endtask

  // receiver holds off while the sender keeps pushing, so full must rise
  task automatic test_backpressure();
    int k;
    settle_queue();
    send_gap_max = 0;
    pop_gap_max = 0;
    pop_hold_req = 80;
    send_beat(MODE_LOAD, 9'd0, 8'd10, 9'd60, 8'd30, 16'h1234);
    for (k = 0; k < 61; k++) send_step();
    settle_queue();
  endtask

  task automatic test_random_lines();
    int phase, goal;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          send_gap_max = 0; pop_gap_max = 0;
        end
        1: begin
          send_gap_max = 7; pop_gap_max = 0;
        end
        2: begin
          send_gap_max = 0; pop_gap_max = 7;
        end
        3: begin
          send_gap_max = 7; pop_gap_max = 7;
        end
        default: begin
          send_gap_max = 3; pop_gap_max = 3;
        end
      endcase
      write_base($urandom);
      goal = useful_beats + 140;
      while (useful_beats < goal) random_line();
    end
    settle_queue();
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // pixel side: random pops, one long hold-off on request
  initial begin
    int pause;
    pix_t want;
    pause = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel beat with none expected: x=%0d y=%0d", pixel_x, pixel_y);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          compare_field("pixel_x", 32'(want.x), 32'(pixel_x));
          compare_field("pixel_y", 32'(want.y), 32'(pixel_y));
          compare_field("pixel_address", want.addr, pixel_address);
          compare_field("pixel_color", 32'(want.color), 32'(pixel_color));
          compare_field("last_pixel", 32'(want.last), 32'(last_pixel));
          pixels_checked++;
        end
        pause = $urandom_range(0, pop_gap_max);
      end
      if (pop_hold_req > 0) begin
        pause = pop_hold_req;
        pop_hold_req = 0;
      end
      if (pause > 0) begin
        pop <= 1'b0;
        pause--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bresenham_line_pixel_generator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    mode <= MODE_LOAD;
    x_start <= '0;
    y_start <= '0;
    x_end <= '0;
    y_end <= '0;
    pen_color <= '0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_points();
    test_flat_lines();
    test_steep_reversed();
    test_load_drops_line();
    test_buffer_base();
    test_backpressure();
    test_random_lines();

    $display("covered %0d line loads and %0d checked pixels over %0d buffer bases,",
             lines_loaded, pixels_checked, base_settings + 1);
    $display("with idle steps, dropped lines, random stalls on both sides and a long hold-off");
    if (error_count == 0) begin
      $display("bresenham_line_pixel_generator regression: pass");
    end else begin
      $display("bresenham_line_pixel_generator regression: fail");
    end
    $finish;
  end

endmodule
